FILE: design/scdt_pkg.sv
// Shared types and constants for the settable countdown timer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package scdt_pkg;

  // Field limits of the shown time
  localparam logic [6:0] HoursMax   = 7'd99;
  localparam logic [5:0] MinSecMax  = 6'd59;
  localparam logic [3:0] TenthsMax  = 4'd9;

  // Register reset values
  localparam logic [7:0] TicksPerStepReset = 8'd6;
  localparam logic [9:0] StickHighReset    = 10'd1000;
  localparam logic [9:0] StickLowReset     = 10'd30;

  // Widths of the stream payloads
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned InUserWidth  = 2;
  localparam int unsigned OutDataWidth = 32;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 10;

  // Kind of an input item
  typedef enum logic [1:0] {
    ActTick    = 2'd0,
    ActEncoder = 2'd1,
    ActStick   = 2'd2,
    ActUnused  = 2'd3
  } action_e;

  // Field under the edit cursor
  typedef enum logic [1:0] {
    CurHours   = 2'd0,
    CurMinutes = 2'd1,
    CurSeconds = 2'd2,
    CurTenths  = 2'd3
  } cursor_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgTicksPerStep = 2'd0,
    CfgStickHigh    = 2'd1,
    CfgStickLow     = 2'd2,
    CfgNone         = 2'd3
  } cfg_idx_e;

  // One input item
  typedef struct packed {
    action_e     action;
    logic        start_button_level;
    logic        reset_button_level;
    logic        turn_down;
    logic [9:0]  stick_sample;
  } item_t;

  // Configuration registers as seen by the update logic
  typedef struct packed {
    logic [7:0] ticks_per_step;
    logic [9:0] stick_high_limit;
    logic [9:0] stick_low_limit;
  } cfg_t;

  // Complete timer state
  typedef struct packed {
    logic [6:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic [3:0] tenths_now;
    logic [6:0] saved_hours;
    logic [5:0] saved_minutes;
    logic [5:0] saved_seconds;
    logic [3:0] saved_tenths;
    logic       running;
    logic       runout;
    logic       start_prev;
    logic       reset_prev;
    logic [7:0] prescale_count;
    cursor_e    cursor_index;
    logic       stick_latched;
  } state_t;

  localparam state_t StateReset = '{
    hours_now:      7'd0,
    minutes_now:    6'd1,
    seconds_now:    6'd0,
    tenths_now:     4'd0,
    saved_hours:    7'd0,
    saved_minutes:  6'd1,
    saved_seconds:  6'd0,
    saved_tenths:   4'd0,
    running:        1'b0,
    runout:         1'b0,
    start_prev:     1'b1,
    reset_prev:     1'b1,
    prescale_count: 8'd0,
    cursor_index:   CurHours,
    stick_latched:  1'b0
  };

endpackage

FILE: design/scdt_in_reg.sv
// Input register of the settable countdown timer: holds one accepted item.
// Depends on scdt_pkg for the item type.
`timescale 1ns / 1ps

module scdt_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  scdt_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            pop_i,
  output scdt_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  scdt_pkg::item_t item_q;

  // The slot takes a new transfer when empty or emptied in this cycle
  assign ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (pop_i) begin
      valid_d = 1'b0;
    end
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: design/scdt_step.sv
// Next-state logic of the settable countdown timer for one item.
// Purely combinational; depends on scdt_pkg for types and limits.
`timescale 1ns / 1ps

module scdt_step (
  input  scdt_pkg::state_t state_i,
  input  scdt_pkg::item_t  item_i,
  input  scdt_pkg::cfg_t   cfg_i,
  output scdt_pkg::state_t state_o
);

  logic       start_edge;
  logic       reset_edge;
  logic [7:0] prescale_inc;

  assign start_edge   = !item_i.start_button_level && state_i.start_prev;
  assign reset_edge   = !item_i.reset_button_level && state_i.reset_prev;
  assign prescale_inc = state_i.prescale_count + 8'd1;

  always_comb begin
    state_o = state_i;
    case (item_i.action)
      scdt_pkg::ActTick: begin
        state_o.start_prev = item_i.start_button_level;
        if (!state_i.running) begin
          // Stopped: start saves the time and runs, reset restores the saved time
          state_o.reset_prev = item_i.reset_button_level;
          if (start_edge) begin
            state_o.saved_hours   = state_i.hours_now;
            state_o.saved_minutes = state_i.minutes_now;
            state_o.saved_seconds = state_i.seconds_now;
            state_o.saved_tenths  = state_i.tenths_now;
            state_o.running       = 1'b1;
          end
          // With start on the same tick the restored values are the current ones
          if (reset_edge && !start_edge) begin
            state_o.hours_now   = state_i.saved_hours;
            state_o.minutes_now = state_i.saved_minutes;
            state_o.seconds_now = state_i.saved_seconds;
            state_o.tenths_now  = state_i.saved_tenths;
          end
        end else begin
          // Running: a stop press halts, the prescaler still counts this tick
          if (start_edge) begin
            state_o.running = 1'b0;
          end
          state_o.prescale_count = prescale_inc;
          if (prescale_inc >= cfg_i.ticks_per_step) begin
            state_o.prescale_count = 8'd0;
            // Step down one tenth with borrows
            if (state_i.tenths_now != 4'd0) begin
              state_o.tenths_now = state_i.tenths_now - 4'd1;
            end else if (state_i.seconds_now != 6'd0) begin
              state_o.tenths_now  = scdt_pkg::TenthsMax;
              state_o.seconds_now = state_i.seconds_now - 6'd1;
            end else if (state_i.minutes_now != 6'd0) begin
              state_o.tenths_now  = scdt_pkg::TenthsMax;
              state_o.seconds_now = scdt_pkg::MinSecMax;
              state_o.minutes_now = state_i.minutes_now - 6'd1;
            end else if (state_i.hours_now != 7'd0) begin
              state_o.tenths_now  = scdt_pkg::TenthsMax;
              state_o.seconds_now = scdt_pkg::MinSecMax;
              state_o.minutes_now = scdt_pkg::MinSecMax;
              state_o.hours_now   = state_i.hours_now - 7'd1;
            end else begin
              // Underflow past zero: clear, stop and latch the runout flag
              state_o.tenths_now  = 4'd0;
              state_o.seconds_now = 6'd0;
              state_o.minutes_now = 6'd0;
              state_o.hours_now   = 7'd0;
              state_o.running     = 1'b0;
              state_o.runout      = 1'b1;
            end
          end
        end
      end

      scdt_pkg::ActEncoder: begin
        // Edit the field under the cursor, saturating at its limits
        if (!state_i.running) begin
          unique case (state_i.cursor_index)
            scdt_pkg::CurHours: begin
              if (item_i.turn_down) begin
                if (state_i.hours_now != 7'd0) state_o.hours_now = state_i.hours_now - 7'd1;
              end else if (state_i.hours_now < scdt_pkg::HoursMax) begin
                state_o.hours_now = state_i.hours_now + 7'd1;
              end
            end
            scdt_pkg::CurMinutes: begin
              if (item_i.turn_down) begin
                if (state_i.minutes_now != 6'd0) begin
                  state_o.minutes_now = state_i.minutes_now - 6'd1;
                end
              end else if (state_i.minutes_now < scdt_pkg::MinSecMax) begin
                state_o.minutes_now = state_i.minutes_now + 6'd1;
              end
            end
            scdt_pkg::CurSeconds: begin
              if (item_i.turn_down) begin
                if (state_i.seconds_now != 6'd0) begin
                  state_o.seconds_now = state_i.seconds_now - 6'd1;
                end
              end else if (state_i.seconds_now < scdt_pkg::MinSecMax) begin
                state_o.seconds_now = state_i.seconds_now + 6'd1;
              end
            end
            default: begin
              if (item_i.turn_down) begin
                if (state_i.tenths_now != 4'd0) state_o.tenths_now = state_i.tenths_now - 4'd1;
              end else if (state_i.tenths_now < scdt_pkg::TenthsMax) begin
                state_o.tenths_now = state_i.tenths_now + 4'd1;
              end
            end
          endcase
        end
      end

      scdt_pkg::ActStick: begin
        // Move the cursor once per excursion; the right side wins if both apply
        if (!state_i.running) begin
          if (item_i.stick_sample > cfg_i.stick_high_limit) begin
            if (!state_i.stick_latched && state_i.cursor_index != scdt_pkg::CurTenths) begin
              state_o.cursor_index = scdt_pkg::cursor_e'(state_i.cursor_index + 2'd1);
            end
            state_o.stick_latched = 1'b1;
          end else if (item_i.stick_sample < cfg_i.stick_low_limit) begin
            if (!state_i.stick_latched && state_i.cursor_index != scdt_pkg::CurHours) begin
              state_o.cursor_index = scdt_pkg::cursor_e'(state_i.cursor_index - 2'd1);
            end
            state_o.stick_latched = 1'b1;
          end else begin
            state_o.stick_latched = 1'b0;
          end
        end
      end

      default: begin
        // Unused kind: state unchanged
      end
    endcase
  end

endmodule

FILE: design/settable_countdown_timer.sv
// Top level of the settable countdown timer: stream ports, configuration registers,
// timer state and result register. Depends on scdt_pkg, scdt_in_reg and scdt_step.
//
//   Channel   Direction  Transfer carries
//   s_axis    in         one item: tuser = action, tdata = button levels, turn, stick
//   m_axis    out        one result: the shown time, flags and cursor after the item
//   cfg       in         one register write, no handshake
//
// An item waits in the input register; the state update and the result are
// registered together on the edge at which it advances, and one item is accepted
// every cycle while results are taken. A stalled result holds both registers;
// the input side keeps accepting until the input register is full.
// Reset is asynchronous and active low and restores the power-up time of one minute.
`timescale 1ns / 1ps

module settable_countdown_timer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Item stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tuser: action[1:0]
  input  logic [scdt_pkg::InUserWidth-1:0]       s_axis_tuser,
  // tdata: start_button_level[0], reset_button_level[1], turn_down[2],
  //        stick_sample[12:3], zero[15:13]
  input  logic [scdt_pkg::InDataWidth-1:0]       s_axis_tdata,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: hours_out[6:0], minutes_out[12:7], seconds_out[18:13], tenths_out[22:19],
  //        running_out[23], runout_out[24], cursor_out[26:25], zero[31:27]
  output logic [scdt_pkg::OutDataWidth-1:0]      m_axis_tdata,
  // Configuration writes
  input  logic                                   cfg_we_i,
  input  logic [scdt_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [scdt_pkg::CfgDataWidth-1:0]      cfg_data_i
);

  scdt_pkg::item_t  item_in;
  scdt_pkg::item_t  item_held;
  logic             held_valid;
  logic             advance;
  scdt_pkg::cfg_t   cfg_q;
  scdt_pkg::state_t state_q;
  scdt_pkg::state_t state_d;
  logic             out_valid_q;
  logic             out_valid_d;
  logic [scdt_pkg::OutDataWidth-1:0] out_data_q;
  logic [scdt_pkg::OutDataWidth-1:0] out_data_d;

  // Unpack the incoming transfer
  assign item_in.action             = scdt_pkg::action_e'(s_axis_tuser);
  assign item_in.start_button_level = s_axis_tdata[0];
  assign item_in.reset_button_level = s_axis_tdata[1];
  assign item_in.turn_down          = s_axis_tdata[2];
  assign item_in.stick_sample       = s_axis_tdata[12:3];

  scdt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (item_in),
    .valid_o (held_valid),
    .pop_i   (advance),
    .item_o  (item_held)
  );

  // The held item is processed when the result register is free or being emptied
  assign advance = held_valid && (!out_valid_q || m_axis_tready);

  scdt_step u_step (
    .state_i (state_q),
    .item_i  (item_held),
    .cfg_i   (cfg_q),
    .state_o (state_d)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_step   <= scdt_pkg::TicksPerStepReset;
      cfg_q.stick_high_limit <= scdt_pkg::StickHighReset;
      cfg_q.stick_low_limit  <= scdt_pkg::StickLowReset;
    end else if (cfg_we_i) begin
      unique case (scdt_pkg::cfg_idx_e'(cfg_index_i))
        scdt_pkg::CfgTicksPerStep: cfg_q.ticks_per_step   <= cfg_data_i[7:0];
        scdt_pkg::CfgStickHigh:    cfg_q.stick_high_limit <= cfg_data_i;
        scdt_pkg::CfgStickLow:     cfg_q.stick_low_limit  <= cfg_data_i;
        default: begin
          // No register at this index
        end
      endcase
    end
  end

  // Timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scdt_pkg::StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_data_d = {5'd0,
                       state_d.cursor_index,
                       state_d.runout,
                       state_d.running,
                       state_d.tenths_now,
                       state_d.seconds_now,
                       state_d.minutes_now,
                       state_d.hours_now};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
